// ----- rtl/iss_pkg.sv -----
// Package for the indexed sequence store: sizes, operation and status codes.
package iss_pkg;

  // Built-in capacity of the store.
  localparam int unsigned CAPACITY = 16;

  // Entry address and entry count widths follow from the capacity.
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;

  // Width used to compare a position against the entry count.
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_REMOVE_AT  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ----- rtl/indexed_sequence_store.sv -----
// Indexed sequence store: ordered list with push, pop, insert and remove.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_stall_o | operation_i, value_i, position_i
//   out     | output    | out_valid_o/out_stall_i | status_o, new_length_o, removed_value_o
//
// Sequence: a failed or unknown request goes from acceptance straight to the result state;
//   a successful one first shifts the entries between the position and the tail. Every moved
//   entry costs one read and one write of the entry memory (one write port, one read port),
//   stepped by one shared pointer adder and compare.
// The block takes no new request until the current one has been loaded into the result
//   register; a result waiting on out_stall_i does not block acceptance of the next request.
// Reset clears the entry count, the sequencer and the result valid; memory contents stay
//   undefined and are never read before being written.
module indexed_sequence_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [iss_pkg::OP_W-1:0]       operation_i,
  input  logic signed [iss_pkg::VAL_W-1:0] value_i,
  input  logic [iss_pkg::POS_W-1:0]      position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [iss_pkg::STATUS_W-1:0]   status_o,
  output logic [iss_pkg::LEN_W-1:0]      new_length_o,
  output logic signed [iss_pkg::VAL_W-1:0] removed_value_o
);

  localparam int unsigned IDX_W = iss_pkg::IDX_W;
  localparam int unsigned CNT_W = iss_pkg::CNT_W;
  localparam int unsigned CMP_W = iss_pkg::CMP_W;
  localparam int unsigned VAL_W = iss_pkg::VAL_W;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,  // wait for a request
    S_FETCH  = 6'b000010,  // read the entry a remove takes out
    S_GRAB   = 6'b000100,  // capture the removed value
    S_READ   = 6'b001000,  // check for the end of the shift, else read the next entry
    S_WRITE  = 6'b010000,  // write the read entry one place over, advance the pointer
    S_RESULT = 6'b100000   // load the result register
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [CNT_W-1:0] count_q, count_d;    // entries held
  logic [CNT_W-1:0] ptr_q, ptr_d;        // walking entry pointer
  logic [CNT_W-1:0] end_q, end_d;        // insert target position
  logic             ins_q, ins_d;        // current shift direction: insert moves up
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic [VAL_W-1:0]            val_q;
  logic [VAL_W-1:0]            taken_q;
  logic [iss_pkg::STATUS_W-1:0] status_q;
  logic [iss_pkg::STATUS_W-1:0] res_status_q;
  logic [iss_pkg::LEN_W-1:0]   res_len_q;
  logic [VAL_W-1:0]            res_taken_q;

  // Entry memory: one write port, one read port with registered data.
  logic [VAL_W-1:0] entries_q [iss_pkg::CAPACITY];
  logic [VAL_W-1:0] rd_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata;

  // Request decode.
  logic                          accept;
  logic                          is_ins, is_rem;
  logic [CMP_W-1:0]              pos_c, cnt_c;
  logic [iss_pkg::STATUS_W-1:0]  dec_status;

  // Shared step unit: one adder and one compare serve every shift.
  logic [CNT_W-1:0] nxt_ptr;
  logic             last;
  logic             res_load;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    cnt_c  = CMP_W'(count_q);
    pos_c  = '0;
    case (operation_i)
      iss_pkg::OP_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      iss_pkg::OP_PUSH_BACK: begin
        is_ins = 1'b1;
        pos_c  = cnt_c;
      end
      iss_pkg::OP_POP_FRONT: begin
        is_rem = 1'b1;
      end
      iss_pkg::OP_POP_BACK: begin
        is_rem = 1'b1;
        pos_c  = CMP_W'(count_q - CNT_W'(1));
      end
      iss_pkg::OP_INSERT_AT: begin
        is_ins = 1'b1;
        pos_c  = CMP_W'(position_i);
      end
      iss_pkg::OP_REMOVE_AT: begin
        is_rem = 1'b1;
        pos_c  = CMP_W'(position_i);
      end
      default: begin
        // unknown operation: report done, change nothing
      end
    endcase

    dec_status = iss_pkg::ST_DONE;
    if (is_ins) begin
      if (count_q == CNT_W'(iss_pkg::CAPACITY)) begin
        dec_status = iss_pkg::ST_FULL;
      end else if (pos_c > cnt_c) begin
        dec_status = iss_pkg::ST_RANGE;
      end
    end else if (is_rem) begin
      if (count_q == '0) begin
        dec_status = iss_pkg::ST_EMPTY;
      end else if (pos_c >= cnt_c) begin
        dec_status = iss_pkg::ST_RANGE;
      end
    end
  end

  // Step the pointer down for an insert, up for a remove.
  assign nxt_ptr = ins_q ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
  assign last    = ins_q ? (ptr_q == end_q) : (nxt_ptr == count_q);

  assign res_load = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q[IDX_W-1:0];
    mem_raddr = nxt_ptr[IDX_W-1:0];
    mem_wdata = (state_q == S_READ) ? val_q : rd_q;
    case (state_q)
      S_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q[IDX_W-1:0];
      end
      S_READ: begin
        if (last) begin
          // insert drops the new value into the freed slot
          mem_we = ins_q;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= entries_q[mem_raddr];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    ins_d       = ins_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ins_d = is_ins;
          end_d = pos_c[CNT_W-1:0];
          if (dec_status != iss_pkg::ST_DONE || !(is_ins || is_rem)) begin
            state_d = S_RESULT;
          end else if (is_ins) begin
            // start at the slot just past the tail and walk down
            ptr_d   = count_q;
            state_d = S_READ;
          end else begin
            ptr_d   = pos_c[CNT_W-1:0];
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_d = S_GRAB;
      end
      S_GRAB: begin
        state_d = S_READ;
      end
      S_READ: begin
        if (last) begin
          count_d = ins_q ? (count_q + CNT_W'(1)) : (count_q - CNT_W'(1));
          state_d = S_RESULT;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ptr_d   = nxt_ptr;
        state_d = S_READ;
      end
      S_RESULT: begin
        if (res_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      end_q       <= '0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      end_q       <= end_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request payload and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q    <= value_i;
      status_q <= dec_status;
      taken_q  <= '0;
    end
    if (state_q == S_GRAB) begin
      taken_q <= rd_q;
    end
    if (res_load) begin
      res_status_q <= status_q;
      res_len_q    <= iss_pkg::LEN_W'(count_q);
      res_taken_q  <= taken_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_status_q;
  assign new_length_o    = res_len_q;
  assign removed_value_o = res_taken_q;

endmodule
